[src/bounded_double_ended_queue_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bounded double-ended queue
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// Check a property at every clock edge outside reset
`define BDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies a condition in the next
`define BDQ_ASSERT_NEXT(lbl, cond, expct, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expct)) \
    else $error(msg);

`endif

[src/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Sizes, action and status codes, and the result word of the queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Queue capacity in elements (2 to 64)
  localparam int DEPTH = 16;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = 32;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;

  // Stream word widths, padded to whole bytes
  localparam int IN_DATA_W  = ((ACT_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

  // Actions
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DUMP       = 3'd4;

  // Result status
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNDER = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVER  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

  // One result word
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] item;
    logic [CNT_W-1:0]         size;
    logic                     last;
  } out_res_t;

endpackage

[src/bdq_ram.sv]
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/bounded_double_ended_queue_unit.sv]
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_unit
// Double-ended queue of signed 32-bit values kept as a ring in one RAM.
// ----------------------------------------------------------------------------
//
// Channel | Direction | tdata (low bit up)         | tuser  | tlast
// --------+-----------+----------------------------+--------+---------------
// in_     | slave     | action[3], value[32], pad  | -      | -
// out_    | master    | item[32], size, pad        | status | last of input
//
// Push and pop words may follow back to back while the output register
// drains. A dump of n elements streams n words through the single RAM
// read port, one per cycle unless an output stall holds a pending read;
// no input word is taken until the last dump word sits in the output
// register. Synchronous reset clears the front index, count and control
// state, not the RAM; output stalls hold the result and any pending read.
//
module bounded_double_ended_queue_unit
  import bdq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // action[2:0], value[34:3], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // item[31:0], size above it, zero pad
  output logic [STAT_W-1:0]     out_tuser,  // status
  output logic                  out_tlast
);

`include "bounded_double_ended_queue_unit_assert.svh"

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic             state_r, state_nxt;
  logic [IDX_W-1:0] fidx_r, fidx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             pend_last_r, pend_last_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_res_t         out_r, out_nxt;

  logic                     in_acc;
  logic                     out_free;
  logic                     load_pend;
  logic                     issue;
  logic [ACT_W-1:0]         act;
  logic [DATA_W-1:0]        val;
  logic                     full;
  logic                     empty;
  logic [IDX_W-1:0]         front_dec;
  logic [IDX_W-1:0]         front_inc;
  logic [IDX_W-1:0]         rptr_inc;
  logic [SUM_W-1:0]         back_sum;
  logic [IDX_W-1:0]         back_idx;
  out_res_t                 res;
  logic                     res_load;
  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [DATA_W-1:0]        rdata;

  // Handshake
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && !rd_pend_r && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign load_pend = rd_pend_r && out_free;
  assign issue     = (state_r == ST_DUMP) && (!rd_pend_r || load_pend);

  assign act = in_tdata[ACT_W-1:0];
  assign val = in_tdata[ACT_W+DATA_W-1:ACT_W];

  // Ring index arithmetic
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign front_dec = (fidx_r == '0) ? IDX_W'(DEPTH - 1) : fidx_r - 1'b1;
  assign front_inc = (fidx_r == IDX_W'(DEPTH - 1)) ? '0 : fidx_r + 1'b1;
  assign rptr_inc  = (rptr_r == IDX_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
  assign back_sum  = SUM_W'(fidx_r) + SUM_W'(count_r);
  assign back_idx  = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(back_sum);

  // Decode the accepted word and update the ring
  always_comb begin
    state_nxt     = state_r;
    fidx_nxt      = fidx_r;
    count_nxt     = count_r;
    rptr_nxt      = rptr_r;
    rem_nxt       = rem_r;
    pend_last_nxt = pend_last_r;
    we            = 1'b0;
    waddr         = front_dec;
    res_load      = 1'b0;
    res.status    = STAT_OK;
    res.item      = '0;
    res.size      = count_r;
    res.last      = 1'b1;

    if (in_acc) begin
      res_load = 1'b1;
      case (act)
        ACT_PUSH_FRONT: begin
          if (full) begin
            res.status = STAT_OVER;
          end else begin
            we        = 1'b1;
            waddr     = front_dec;
            fidx_nxt  = front_dec;
            count_nxt = count_r + 1'b1;
          end
        end
        ACT_PUSH_BACK: begin
          if (full) begin
            res.status = STAT_OVER;
          end else begin
            we        = 1'b1;
            waddr     = back_idx;
            count_nxt = count_r + 1'b1;
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            res.status = STAT_UNDER;
          end else begin
            count_nxt = count_r - 1'b1;
            fidx_nxt  = (count_r == CNT_W'(1)) ? '0 : front_inc;
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            res.status = STAT_UNDER;
          end else begin
            count_nxt = count_r - 1'b1;
            if (count_r == CNT_W'(1)) begin
              fidx_nxt = '0;
            end
          end
        end
        ACT_DUMP: begin
          if (empty) begin
            res.status = STAT_EMPTY;
          end else begin
            res_load  = 1'b0;
            state_nxt = ST_DUMP;
            rptr_nxt  = fidx_r;
            rem_nxt   = count_r;
          end
        end
        default: begin
          res.status = STAT_OK;
        end
      endcase
      res.size = count_nxt;
    end

    // Walk the ring from front to back, one read per cycle unless an output stall holds a pending read
    if (issue) begin
      rptr_nxt      = rptr_inc;
      rem_nxt       = rem_r - 1'b1;
      pend_last_nxt = (rem_r == CNT_W'(1));
      if (rem_r == CNT_W'(1)) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  // Track the read word in flight
  always_comb begin
    rd_pend_nxt = rd_pend_r;
    if (issue) begin
      rd_pend_nxt = 1'b1;
    end else if (load_pend) begin
      rd_pend_nxt = 1'b0;
    end
  end

  // Load the output register from a direct result or a dump read
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (load_pend) begin
      out_valid_nxt  = 1'b1;
      out_nxt.status = STAT_OK;
      out_nxt.item   = rdata;
      out_nxt.size   = count_r;
      out_nxt.last   = pend_last_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fidx_r      <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fidx_r      <= fidx_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    rptr_r      <= rptr_nxt;
    pend_last_r <= pend_last_nxt;
    out_r       <= out_nxt;
  end

  // Element store
  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (val),
    .re    (issue),
    .raddr (rptr_r),
    .rdata (rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_r.size, out_r.item});
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.last;

  // Checks
  `BDQ_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "element count above capacity")
  `BDQ_ASSERT(a_empty_front, (count_r != '0) || (fidx_r == '0), "empty queue with front off zero")
  `BDQ_ASSERT(a_write_on_accept, !we || in_acc, "store written without an accepted word")
  `BDQ_ASSERT(a_single_source, !(res_load && load_pend), "two results loaded at once")
  `BDQ_ASSERT_NEXT(a_pend_held, rd_pend_r && out_valid_r && !out_tready, rd_pend_r,
    "pending dump word dropped under stall")

endmodule
